@@ src/mml_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mml_pkg;

  // Limb, limb count register and configuration port widths.
  localparam int unsigned LimbW     = 32;
  localparam int unsigned LimbCntW  = 4;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 32;

  // Default capacity of the operand stores, in limbs.
  localparam int unsigned MaxLimbs  = 12;

  localparam logic [LimbCntW-1:0] LimbCountReset = LimbCntW'(12);
  localparam logic [LimbW-1:0]    MontConstReset = '0;

  typedef enum logic [CfgIdxW-1:0] {
    RegMontConst = CfgIdxW'(0),
    RegLimbCount = CfgIdxW'(1)
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ src/mml_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Operand limb channel.
interface mml_in_if;
  logic                     valid;
  logic                     ready;
  logic [mml_pkg::LimbW-1:0] a_limb;
  logic [mml_pkg::LimbW-1:0] b_limb;
  logic [mml_pkg::LimbW-1:0] mod_limb;

  modport source (output valid, output a_limb, output b_limb, output mod_limb, input ready);
  modport sink   (input valid, input a_limb, input b_limb, input mod_limb, output ready);
endinterface

// Result limb channel.
interface mml_out_if;
  logic                     valid;
  logic                     ready;
  logic [mml_pkg::LimbW-1:0] result_limb;
  logic                     last_limb;

  modport source (output valid, output result_limb, output last_limb, input ready);
  modport sink   (input valid, input result_limb, input last_limb, output ready);
endinterface

// Register write channel.
interface mml_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mml_pkg::CfgIdxW-1:0]  reg_index;
  logic [mml_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ src/montgomery_multiply_limbs.sv @@
// Loading: one limb transaction per cycle while idle; the transaction carrying the last limb
// starts the product. The product is computed by the single 32x32 multiplier and its
// read/multiply/accumulate pipeline, which runs 2*n passes of n limbs each. Each result limb
// is read from the stores, then loaded into the output register once that register is free.
// Reset is asynchronous and active low; it clears control state and the registers
// (limb count 12, Montgomery constant 0). Limb stores hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module montgomery_multiply_limbs #(
  parameter int unsigned MAX_LIMBS = mml_pkg::MaxLimbs
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mml_in_if.sink     in_i,
  mml_out_if.source  out_o,
  mml_cfg_if.sink    cfg_i
);

  localparam int unsigned LimbW = mml_pkg::LimbW;
  localparam int unsigned CntW  = $clog2(MAX_LIMBS + 1);
  localparam int unsigned IdxW  = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;

  typedef enum logic [3:0] {
    StIdle,
    StMulPass,
    StMulDrain,
    StQMul,
    StQTake,
    StRedPass,
    StRedDrain,
    StSubPass,
    StSubDrain,
    StOutRd,
    StOutLd
  } state_e;

  typedef struct packed {
    logic            valid;
    logic            red;
    logic            sub;
    logic            zero;
    logic            first;
    logic [IdxW-1:0] idx;
  } stage_t;

  state_e state_q, state_d;

  logic [LimbW-1:0]            mont_q, mont_d;
  logic [mml_pkg::LimbCntW-1:0] limb_cnt_q, limb_cnt_d;
  logic [CntW-1:0]             loaded_q, loaded_d;
  logic [CntW-1:0]             i_q, i_d;
  logic [CntW-1:0]             j_q, j_d;
  logic                        tc_q, tc_d;
  logic                        borrow_q, borrow_d;
  logic [LimbW-1:0]            hi_q, hi_d;
  logic [LimbW-1:0]            top_q, top_d;
  logic [LimbW-1:0]            acc0_q, acc0_d;
  logic [LimbW-1:0]            q_q, q_d;
  logic [LimbW-1:0]            mask_q, mask_d;
  stage_t                      s1_q, s1_d;
  stage_t                      s2_q, s2_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_last_q, out_last_d;
  logic [LimbW-1:0]            out_data_q, out_data_d;

  // Limb stores, accumulator and difference words.
  logic [LimbW-1:0] a_mem    [MAX_LIMBS];
  logic [LimbW-1:0] b_mem    [MAX_LIMBS];
  logic [LimbW-1:0] m_mem    [MAX_LIMBS];
  logic [LimbW-1:0] acc_mem  [MAX_LIMBS];
  logic [LimbW-1:0] diff_mem [MAX_LIMBS];

  logic [LimbW-1:0] a_rd_q, b_rd_q, m_rd_q, acc_rd_q, diff_rd_q, acc_s2_q;
  logic [2*LimbW-1:0] prod_q;

  logic [31:0]     lc_ext;
  logic [31:0]     n_ext;
  logic [CntW-1:0] n_act;
  logic [CntW-1:0] n_last;
  logic [CntW-1:0] load_ptr;
  logic            in_acc;
  logic            cfg_acc;
  logic [IdxW-1:0] rd_idx;

  logic [LimbW-1:0]   mul_x, mul_y;
  logic [2*LimbW-1:0] mul_p;
  logic [2*LimbW-1:0] mac_sum;
  logic [LimbW:0]     sub_sum;
  logic [LimbW:0]     tail_sum;

  logic             acc_we;
  logic [IdxW-1:0]  acc_waddr;
  logic [LimbW-1:0] acc_wdata;
  logic             diff_we;

  // Effective limb count: zero acts as one, large values saturate.
  always_comb begin
    lc_ext = 32'(limb_cnt_q);
    if (lc_ext == 32'd0) begin
      n_ext = 32'd1;
    end else if (lc_ext > MAX_LIMBS) begin
      n_ext = MAX_LIMBS;
    end else begin
      n_ext = lc_ext;
    end
    n_act  = CntW'(n_ext);
    n_last = n_act - CntW'(1);
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign load_ptr = (loaded_q >= n_act) ? '0 : loaded_q;
  assign rd_idx   = i_q[IdxW-1:0];

  assign in_i.ready        = (state_q == StIdle);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.result_limb = out_data_q;
  assign out_o.last_limb   = out_last_q;

  // The shared multiplier: quotient digit, reduction or partial product.
  always_comb begin
    if (state_q == StQMul) begin
      mul_x = mont_q;
      mul_y = acc0_q;
    end else if (s1_q.red) begin
      mul_x = q_q;
      mul_y = m_rd_q;
    end else begin
      mul_x = b_rd_q;
      mul_y = a_rd_q;
    end
  end
  assign mul_p = {{LimbW{1'b0}}, mul_x} * {{LimbW{1'b0}}, mul_y};

  // Accumulate stage: product plus carry word plus accumulator word.
  assign mac_sum = prod_q
                 + {{LimbW{1'b0}}, (s2_q.first ? '0 : hi_q)}
                 + {{LimbW{1'b0}}, (s2_q.zero ? '0 : acc_s2_q)};

  assign sub_sum = {1'b0, acc_rd_q} - {1'b0, m_rd_q}
                 - {{LimbW{1'b0}}, (s1_q.first ? 1'b0 : borrow_q)};

  assign diff_we = s1_q.valid && s1_q.sub;

  always_comb begin
    state_d     = state_q;
    mont_d      = mont_q;
    limb_cnt_d  = limb_cnt_q;
    loaded_d    = loaded_q;
    i_d         = i_q;
    j_d         = j_q;
    tc_d        = tc_q;
    borrow_d    = borrow_q;
    hi_d        = hi_q;
    top_d       = top_q;
    acc0_d      = acc0_q;
    q_d         = q_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;
    acc_we      = 1'b0;
    acc_waddr   = s2_q.idx;
    acc_wdata   = mac_sum[LimbW-1:0];
    tail_sum    = '0;

    s1_d.valid = (state_q == StMulPass) || (state_q == StRedPass) || (state_q == StSubPass);
    s1_d.red   = (state_q == StRedPass);
    s1_d.sub   = (state_q == StSubPass);
    s1_d.zero  = (state_q == StMulPass) && (j_q == '0);
    s1_d.first = (i_q == '0);
    s1_d.idx   = rd_idx;

    s2_d       = s1_q;
    s2_d.valid = s1_q.valid && !s1_q.sub;

    if (s2_q.valid) begin
      hi_d = mac_sum[2*LimbW-1:LimbW];
      if (!s2_q.red) begin
        acc_we = 1'b1;
        if (s2_q.first) begin
          acc0_d = mac_sum[LimbW-1:0];
        end
      end else if (!s2_q.first) begin
        // Reduction shifts the accumulator down by one word.
        acc_we    = 1'b1;
        acc_waddr = IdxW'(s2_q.idx - IdxW'(1));
      end
    end

    if (diff_we) begin
      borrow_d = sub_sum[LimbW];
    end

    if (cfg_acc) begin
      unique case (mml_pkg::cfg_reg_e'(cfg_i.reg_index))
        mml_pkg::RegMontConst: begin
          mont_d = cfg_i.wdata;
        end
        mml_pkg::RegLimbCount: begin
          limb_cnt_d = cfg_i.wdata[mml_pkg::LimbCntW-1:0];
          loaded_d   = '0;
        end
        default: begin
        end
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (load_ptr == n_last) begin
            loaded_d = '0;
            i_d      = '0;
            j_d      = '0;
            tc_d     = 1'b0;
            state_d  = StMulPass;
          end else begin
            loaded_d = load_ptr + CntW'(1);
          end
        end
      end
      StMulPass: begin
        if (i_q == n_last) begin
          i_d     = '0;
          state_d = StMulDrain;
        end else begin
          i_d = i_q + CntW'(1);
        end
      end
      StMulDrain: begin
        if (!s1_q.valid && !s2_q.valid) begin
          tail_sum = {1'b0, hi_q} + {{LimbW{1'b0}}, tc_q};
          top_d    = tail_sum[LimbW-1:0];
          tc_d     = tail_sum[LimbW];
          state_d  = StQMul;
        end
      end
      StQMul: begin
        state_d = StQTake;
      end
      StQTake: begin
        q_d     = prod_q[LimbW-1:0];
        i_d     = '0;
        state_d = StRedPass;
      end
      StRedPass: begin
        if (i_q == n_last) begin
          i_d     = '0;
          state_d = StRedDrain;
        end else begin
          i_d = i_q + CntW'(1);
        end
      end
      StRedDrain: begin
        if (!s1_q.valid && !s2_q.valid) begin
          tail_sum  = {1'b0, top_q} + {1'b0, hi_q} + {{LimbW{1'b0}}, tc_q};
          acc_we    = 1'b1;
          acc_waddr = n_last[IdxW-1:0];
          acc_wdata = tail_sum[LimbW-1:0];
          tc_d      = tail_sum[LimbW];
          i_d       = '0;
          if (j_q == n_last) begin
            state_d = StSubPass;
          end else begin
            j_d     = j_q + CntW'(1);
            state_d = StMulPass;
          end
        end
      end
      StSubPass: begin
        if (i_q == n_last) begin
          i_d     = '0;
          state_d = StSubDrain;
        end else begin
          i_d = i_q + CntW'(1);
        end
      end
      StSubDrain: begin
        if (!s1_q.valid) begin
          mask_d  = LimbW'(tc_q) - LimbW'(borrow_q);
          state_d = StOutRd;
        end
      end
      StOutRd: begin
        // The read issued here lands in the read registers; StOutLd moves it into the output register.
        if (!out_valid_q) begin
          state_d = StOutLd;
        end
      end
      StOutLd: begin
        out_valid_d = 1'b1;
        out_data_d  = (diff_rd_q & ~mask_q) | (acc_rd_q & mask_q);
        out_last_d  = (i_q == n_last);
        if (i_q == n_last) begin
          i_d     = '0;
          state_d = StIdle;
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = StOutRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mont_q      <= mml_pkg::MontConstReset;
      limb_cnt_q  <= mml_pkg::LimbCountReset;
      loaded_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      tc_q        <= 1'b0;
      borrow_q    <= 1'b0;
      hi_q        <= '0;
      top_q       <= '0;
      acc0_q      <= '0;
      q_q         <= '0;
      mask_q      <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      mont_q      <= mont_d;
      limb_cnt_q  <= limb_cnt_d;
      loaded_q    <= loaded_d;
      i_q         <= i_d;
      j_q         <= j_d;
      tc_q        <= tc_d;
      borrow_q    <= borrow_d;
      hi_q        <= hi_d;
      top_q       <= top_d;
      acc0_q      <= acc0_d;
      q_q         <= q_d;
      mask_q      <= mask_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_data_q  <= out_data_d;
    end
  end

  // Memories with registered read data, and the datapath pipeline registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_mem[load_ptr[IdxW-1:0]] <= in_i.a_limb;
      b_mem[load_ptr[IdxW-1:0]] <= in_i.b_limb;
      m_mem[load_ptr[IdxW-1:0]] <= in_i.mod_limb;
    end
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (diff_we) begin
      diff_mem[s1_q.idx] <= sub_sum[LimbW-1:0];
    end
    a_rd_q    <= a_mem[rd_idx];
    b_rd_q    <= b_mem[j_q[IdxW-1:0]];
    m_rd_q    <= m_mem[rd_idx];
    acc_rd_q  <= acc_mem[rd_idx];
    diff_rd_q <= diff_mem[rd_idx];
    acc_s2_q  <= acc_rd_q;
    prod_q    <= mul_p;
  end

endmodule

`default_nettype wire

@@ src/mml_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mml_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [mml_pkg::LimbW-1:0] out_result_i,
  input wire logic                      out_last_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_result_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  // The block only goes busy after taking an operand limb.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("input ready dropped without a transaction");

  // Results are produced only while the input side is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while the block was idle");

  // Nothing follows the final limb of a product right away.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
    else $error("result offered directly after the final limb");

endmodule

bind montgomery_multiply_limbs mml_checker u_mml_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result_limb),
  .out_last_i   (out_o.last_limb)
);

`default_nettype wire

@@ tb/montgomery_multiply_limbs_tb.sv @@
`timescale 1ns / 1ps

module montgomery_multiply_limbs_tb;

  localparam int unsigned LimbW    = mml_pkg::LimbW;
  localparam int unsigned LimbCntW = mml_pkg::LimbCntW;
  localparam int unsigned CfgIdxW  = mml_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = mml_pkg::CfgDataW;
  localparam int unsigned MaxLimbs = mml_pkg::MaxLimbs;

  localparam int unsigned RandomItems = 100;
  localparam int unsigned LongHold = 300;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegIndexMax = '1;

  typedef struct packed {
    logic [LimbW-1:0] a_limb;
    logic [LimbW-1:0] b_limb;
    logic [LimbW-1:0] mod_limb;
  } limb_item_t;

  typedef struct packed {
    logic [LimbW-1:0] limb;
    logic             last;
  } result_limb_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mml_in_if  in_if ();
  mml_out_if out_if ();
  mml_cfg_if cfg_if ();

  montgomery_multiply_limbs u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  limb_item_t   pending_limbs[$];
  result_limb_t expected_limbs[$];
  limb_item_t   next_item;
  int unsigned  mismatch_count = 0;

  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 56;
  int unsigned stall_req_cnt = 0;
  int unsigned stall_seen_cnt;
  int unsigned hold_left;

  // Shadow copy of the block's registers and operand stores.
  logic [LimbW-1:0]    mont_k = mml_pkg::MontConstReset;
  logic [LimbCntW-1:0] limb_cfg = mml_pkg::LimbCountReset;
  int unsigned         loaded_limbs = 0;
  logic [LimbW-1:0]    a_held [MaxLimbs];
  logic [LimbW-1:0]    b_held [MaxLimbs];
  logic [LimbW-1:0]    m_held [MaxLimbs];

  // Stimulus scratch: one modulus and one operand pair.
  logic [LimbW-1:0] mod_val [MaxLimbs];
  logic [LimbW-1:0] a_val [MaxLimbs];
  logic [LimbW-1:0] b_val [MaxLimbs];

  function automatic int unsigned active_limbs();
    if (limb_cfg == 0) return 1;
    if (limb_cfg > MaxLimbs) return MaxLimbs;
    return limb_cfg;
  endfunction

  // Word-serial Montgomery product of the held operands; queues n result limbs.
  task automatic mont_product_predict(input int unsigned n);
    logic [LimbW-1:0] t [MaxLimbs+1];
    logic [LimbW-1:0] diff [MaxLimbs];
    logic [63:0]      acc;
    logic [LimbW-1:0] q, hi, mask;
    logic             carry, borrow;
    result_limb_t     res;
    int unsigned      i, j;
    carry = 1'b0;
    hi = '0;
    for (i = 0; i < n; i++) begin
      acc = 64'(b_held[0]) * 64'(a_held[i]) + 64'(hi);
      t[i] = acc[31:0];
      hi = acc[63:32];
    end
    t[n] = hi;
    q = mont_k * t[0];
    for (j = 1; j <= n; j++) begin
      acc = 64'(q) * 64'(m_held[0]) + 64'(t[0]);
      hi = acc[63:32];
      for (i = 1; i < n; i++) begin
        acc = 64'(q) * 64'(m_held[i]) + 64'(hi) + 64'(t[i]);
        t[i-1] = acc[31:0];
        hi = acc[63:32];
      end
      acc = 64'(t[n]) + 64'(hi) + 64'(carry);
      t[n-1] = acc[31:0];
      carry = acc[32];
      if (j < n) begin
        hi = '0;
        for (i = 0; i < n; i++) begin
          acc = 64'(b_held[j]) * 64'(a_held[i]) + 64'(hi) + 64'(t[i]);
          t[i] = acc[31:0];
          hi = acc[63:32];
        end
        q = mont_k * t[0];
        acc = 64'(hi) + 64'(carry);
        t[n] = acc[31:0];
        carry = acc[32];
      end
    end
    borrow = 1'b0;
    for (i = 0; i < n; i++) begin
      acc = 64'(t[i]) - (64'(m_held[i]) + 64'(borrow));
      diff[i] = acc[31:0];
      borrow = acc[32];
    end
    // The mask is a plain 32-bit difference, so carry without borrow yields one.
    mask = 32'(carry) - 32'(borrow);
    for (i = 0; i < n; i++) begin
      res.limb = (diff[i] & ~mask) | (t[i] & mask);
      res.last = (i + 1 == n);
      expected_limbs.push_back(res);
    end
  endtask

  task automatic absorb_limb(input limb_item_t item);
    int unsigned n;
    n = active_limbs();
    if (loaded_limbs >= n) loaded_limbs = 0;
    a_held[loaded_limbs] = item.a_limb;
    b_held[loaded_limbs] = item.b_limb;
    m_held[loaded_limbs] = item.mod_limb;
    loaded_limbs++;
    if (loaded_limbs == n) begin
      loaded_limbs = 0;
      mont_product_predict(n);
    end
  endtask

  task automatic apply_reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    if (idx == mml_pkg::RegMontConst) begin
      mont_k = data;
    end else if (idx == mml_pkg::RegLimbCount) begin
      limb_cfg = data[LimbCntW-1:0];
      loaded_limbs = 0;
    end
  endtask

  // Limb transactions toward the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.a_limb <= '0;
      in_if.b_limb <= '0;
      in_if.mod_limb <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        absorb_limb('{in_if.a_limb, in_if.b_limb, in_if.mod_limb});
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_limbs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_limbs.pop_front();
          in_if.valid <= 1'b1;
          in_if.a_limb <= next_item.a_limb;
          in_if.b_limb <= next_item.b_limb;
          in_if.mod_limb <= next_item.mod_limb;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, with an occasional long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      stall_seen_cnt <= 0;
    end else if (stall_seen_cnt != stall_req_cnt) begin
      stall_seen_cnt <= stall_req_cnt;
      hold_left <= LongHold;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_limb_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_limbs.size() == 0) begin
        $error("result_limb %h arrived with no product pending", out_if.result_limb);
        mismatch_count++;
      end else begin
        want = expected_limbs.pop_front();
        if (out_if.result_limb !== want.limb) begin
          $error("result_limb: expected %h, got %h", want.limb, out_if.result_limb);
          mismatch_count++;
        end
        if (out_if.last_limb !== want.last) begin
          $error("last_limb: expected %b, got %b", want.last, out_if.last_limb);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [LimbW-1:0] neg_inv(input logic [LimbW-1:0] p);
    logic [LimbW-1:0] inv;
    inv = p;
    repeat (5) inv = inv * (32'd2 - p * inv);
    return -inv;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg_write(idx, data);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Returns once every limb has been handed over and every result has come back.
  task automatic wait_drained();
    int unsigned settle;
    @(negedge clk_i);
    while (pending_limbs.size() != 0 || in_if.valid || expected_limbs.size() != 0)
      @(negedge clk_i);
    settle = 2 * active_limbs() * active_limbs() + 13 * active_limbs() + 8;
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic push_item(input logic [LimbW-1:0] a, input logic [LimbW-1:0] b,
                           input logic [LimbW-1:0] m);
    pending_limbs.push_back('{a, b, m});
  endtask

  task automatic gen_modulus(input int unsigned n, input bit even);
    for (int unsigned i = 0; i < n; i++) mod_val[i] = $urandom;
    if ($urandom_range(3) == 0) mod_val[n-1] = $urandom_range(255, 1);
    if (mod_val[n-1] == 0) mod_val[n-1] = 1;
    mod_val[0][0] = !even;
  endtask

  // Operands stay below the modulus unless wide is set.
  task automatic fill_operands(input int unsigned n, input bit wide);
    for (int unsigned i = 0; i < n; i++) begin
      a_val[i] = $urandom;
      b_val[i] = $urandom;
    end
    if (!wide) begin
      a_val[n-1] = (mod_val[n-1] == 0) ? '0 : $urandom_range(mod_val[n-1] - 1, 0);
      b_val[n-1] = (mod_val[n-1] == 0) ? '0 : $urandom_range(mod_val[n-1] - 1, 0);
    end
  endtask

  task automatic push_limbs(input int unsigned first, input int unsigned last);
    for (int unsigned i = first; i <= last; i++) push_item(a_val[i], b_val[i], mod_val[i]);
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned cfg_n, n_eff, products, pick;
    bit          long_stall_done;
    logic [CfgDataW-1:0] cnt_wdata;
    rand_items = 0;
    long_stall_done = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.a_limb = '0;
    in_if.b_limb = '0;
    in_if.mod_limb = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single limb at the top of the range, then zero operands.
    write_reg(mml_pkg::RegLimbCount, 1);
    write_reg(mml_pkg::RegMontConst, neg_inv(32'hFFFF_FFFF));
    push_item(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    push_item(32'h0, 32'h0, 32'hFFFF_FFFF);
    wait_drained();

    // A limb count of zero behaves as one limb; modulus one gives an all-ones constant.
    write_reg(mml_pkg::RegLimbCount, 0);
    write_reg(mml_pkg::RegMontConst, 32'hFFFF_FFFF);
    push_item(32'h0, 32'h0, 32'h1);
    wait_drained();
    // Even (zero) modulus with a zero constant and operands far above it.
    write_reg(mml_pkg::RegMontConst, 32'h0);
    push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    wait_drained();

    // Two-limb all-ones modulus with operands one below it.
    write_reg(mml_pkg::RegLimbCount, 2);
    write_reg(mml_pkg::RegMontConst, neg_inv(32'hFFFF_FFFF));
    push_item(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // A constant written between limbs keeps the limbs already loaded.
    write_reg(mml_pkg::RegLimbCount, 3);
    gen_modulus(3, 1'b0);
    fill_operands(3, 1'b0);
    push_limbs(0, 0);
    wait_drained();
    write_reg(mml_pkg::RegMontConst, neg_inv(mod_val[0]));
    push_limbs(1, 2);
    wait_drained();

    // A limb count written between limbs throws the loaded limbs away.
    write_reg(mml_pkg::RegLimbCount, 2);
    gen_modulus(2, 1'b0);
    write_reg(mml_pkg::RegMontConst, neg_inv(mod_val[0]));
    fill_operands(2, 1'b0);
    push_limbs(0, 0);
    wait_drained();
    write_reg(mml_pkg::RegLimbCount, 2);
    push_limbs(0, 1);
    wait_drained();

    // Writes to unused indexes must leave both registers alone.
    write_reg(RegFirstUnused, $urandom);
    write_reg(RegIndexMax, $urandom);

    // Counts above the store size saturate to the full twelve limbs.
    write_reg(mml_pkg::RegLimbCount, 15);
    gen_modulus(MaxLimbs, 1'b0);
    write_reg(mml_pkg::RegMontConst, neg_inv(mod_val[0]));
    fill_operands(MaxLimbs, 1'b0);
    push_limbs(0, MaxLimbs - 1);
    wait_drained();

    // Only the low four bits of the data word set the limb count.
    write_reg(mml_pkg::RegLimbCount, 32'hFFFF_FFF1);
    gen_modulus(1, 1'b0);
    write_reg(mml_pkg::RegMontConst, neg_inv(mod_val[0]));
    fill_operands(1, 1'b0);
    push_limbs(0, 0);

    while (rand_items < RandomItems) begin
      wait_drained();
      if (rand_items >= 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_items >= RandomItems / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 23;
      end
      if (send_idle_pct == 0 && !long_stall_done) begin
        // Hold off the result side while several products queue up behind it.
        long_stall_done = 1'b1;
        write_reg(mml_pkg::RegLimbCount, 2);
        gen_modulus(2, 1'b0);
        write_reg(mml_pkg::RegMontConst, neg_inv(mod_val[0]));
        stall_req_cnt++;
        repeat (4) begin
          fill_operands(2, 1'b0);
          push_limbs(0, 1);
        end
        rand_items += 8;
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) cfg_n = $urandom_range(3, 1);
        else if (pick < 78) cfg_n = $urandom_range(6, 4);
        else if (pick < 88) cfg_n = $urandom_range(MaxLimbs, 7);
        else if (pick < 94) cfg_n = 0;
        else cfg_n = $urandom_range(15, 13);
        n_eff = (cfg_n == 0) ? 1 : (cfg_n > MaxLimbs) ? MaxLimbs : cfg_n;
        gen_modulus(n_eff, $urandom_range(9) == 0);
        cnt_wdata = $urandom_range(1) ? (($urandom & 32'hFFFF_FFF0) | cfg_n) : cfg_n;
        write_reg(mml_pkg::RegLimbCount, cnt_wdata);
        write_reg(mml_pkg::RegMontConst,
                  ($urandom_range(9) == 0) ? $urandom : neg_inv(mod_val[0]));
        if ($urandom_range(6) == 0)
          write_reg(CfgIdxW'($urandom_range(RegIndexMax, RegFirstUnused)), $urandom);
        products = (n_eff > 6) ? 1 : $urandom_range(4, 1);
        repeat (products) begin
          fill_operands(n_eff, $urandom_range(9) == 0);
          push_limbs(0, n_eff - 1);
        end
        rand_items += products * n_eff;
        // Now and then a partial operand set, dropped by the next limb count write.
        if (n_eff > 1 && $urandom_range(5) == 0) begin
          fill_operands(n_eff, 1'b0);
          push_limbs(0, $urandom_range(n_eff - 2, 0));
        end
      end
    end

    wait_drained();
    repeat (500) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("[montgomery_multiply_limbs] OK");
    end else begin
      $display("[montgomery_multiply_limbs] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[montgomery_multiply_limbs] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
src/mml_pkg.sv
src/mml_if.sv
src/montgomery_multiply_limbs.sv
src/mml_checker.sv
tb/montgomery_multiply_limbs_tb.sv
